/* hw/rtl/spmq_pkg.sv */
package spmq_pkg;

  localparam int LEVEL_COUNT_DEF = 8;
  localparam int FIFO_DEPTH_DEF  = 16;

  localparam int PRIO_W      = 4;
  localparam int PAYLOAD_W   = 32;
  localparam int LEVEL_OUT_W = 3;
  localparam int CAP_W       = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // widest store address over the parameter range (16 levels x 256 slots)
  localparam int MAX_ADDR_W = 12;

  // entries in the queue between the front and the back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    ST_ADDED   = 2'd0,
    ST_DROPPED = 2'd1,
    ST_TAKEN   = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef enum logic {
    ACT_ADD  = 1'b0,
    ACT_TAKE = 1'b1
  } action_t;

  typedef struct packed {
    op_t                    op;
    logic [MAX_ADDR_W-1:0]  addr;
    logic [PAYLOAD_W-1:0]   data;
    status_t                status;
    logic [LEVEL_OUT_W-1:0] level;
  } job_t;

endpackage

/* hw/rtl/spmq_in_if.sv */
interface spmq_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [3:0]  priority_req;
  logic [31:0] payload;

  modport source (output valid, action, priority_req, payload, input ready);
  modport sink   (input valid, action, priority_req, payload, output ready);
endinterface

/* hw/rtl/spmq_out_if.sv */
interface spmq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] payload_out;
  logic [2:0]  level_out;

  modport source (output valid, status, payload_out, level_out, input ready);
  modport sink   (input valid, status, payload_out, level_out, output ready);
endinterface

/* hw/rtl/strict_priority_multi_queue.sv */
// Strict-priority queue of 32-bit task handles, one ring FIFO per level, level 0 most
// urgent. An add stores its handle at the tail of its level (levels at or above
// LEVEL_COUNT go to level 0) or reports it dropped when the level already holds
// capacity_in_use entries; a take pops the head of the lowest non-empty level or
// reports all empty. The front keeps pointers and fill counts and settles each
// request in the cycle it is accepted; a two-entry queue then carries it to the back,
// which owns the single-port handle store and the output register. One request is
// accepted per cycle while the queue has room; the result goes through the queue and
// then the output register before it is offered. The sustained rate of one per cycle
// while results are taken is set by the one store access per request. The store is
// not cleared at reset, so no warm-up time is needed. The user writes capacity_in_use
// through cfg_we/cfg_wdata only while no request is in flight; this is not checked.
module strict_priority_multi_queue #(
  parameter int LEVEL_COUNT = spmq_pkg::LEVEL_COUNT_DEF,
  parameter int FIFO_DEPTH  = spmq_pkg::FIFO_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [spmq_pkg::CAP_W-1:0] cfg_wdata,
  spmq_in_if.sink                    req,
  spmq_out_if.source                 rsp
);

  logic           push_valid;
  logic           push_ready;
  spmq_pkg::job_t push_job;
  logic           pop_valid;
  logic           pop_ready;
  spmq_pkg::job_t pop_job;

  spmq_front #(
    .LEVEL_COUNT (LEVEL_COUNT),
    .FIFO_DEPTH  (FIFO_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .req        (req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  spmq_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  spmq_back #(
    .LEVEL_COUNT (LEVEL_COUNT),
    .FIFO_DEPTH  (FIFO_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .rsp       (rsp)
  );

endmodule

/* hw/rtl/spmq_front.sv */
module spmq_front #(
  parameter int LEVEL_COUNT = spmq_pkg::LEVEL_COUNT_DEF,
  parameter int FIFO_DEPTH  = spmq_pkg::FIFO_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [spmq_pkg::CAP_W-1:0]    cfg_wdata,
  spmq_in_if.sink                       req,
  output logic                          push_valid,
  input  logic                          push_ready,
  output spmq_pkg::job_t                push_job
);

  localparam int LVL_W = $clog2(LEVEL_COUNT);
  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  logic [spmq_pkg::CAP_W-1:0] capacity;
  logic [PTR_W-1:0] rd_ptr [LEVEL_COUNT];
  logic [PTR_W-1:0] wr_ptr [LEVEL_COUNT];
  logic [CNT_W-1:0] fill   [LEVEL_COUNT];

  logic [CNT_W-1:0] cap_eff;
  logic [LVL_W-1:0] add_lvl;
  logic [LVL_W-1:0] take_lvl;
  logic             found;
  logic             is_take;
  logic             add_full;
  logic [CNT_W-1:0] wr_inc;
  logic [CNT_W-1:0] rd_inc;
  logic [PTR_W-1:0] wr_adv;
  logic [PTR_W-1:0] rd_adv;
  logic             accept;

  assign accept     = req.valid && push_ready;
  assign req.ready  = push_ready;
  assign push_valid = req.valid;
  assign is_take    = (req.action == spmq_pkg::ACT_TAKE);

  always_comb begin
    if (capacity == '0) begin
      cap_eff = CNT_W'(1);
    end else if (32'(capacity) > 32'(FIFO_DEPTH)) begin
      cap_eff = CNT_W'(FIFO_DEPTH);
    end else begin
      cap_eff = CNT_W'(capacity);
    end
  end

  // out-of-range levels fold onto level 0
  assign add_lvl = (32'(req.priority_req) >= 32'(LEVEL_COUNT)) ? '0
                                                               : LVL_W'(req.priority_req);

  always_comb begin
    found    = 1'b0;
    take_lvl = '0;
    for (int i = LEVEL_COUNT - 1; i >= 0; i--) begin
      if (fill[i] != '0) begin
        found    = 1'b1;
        take_lvl = LVL_W'(i);
      end
    end
  end

  assign add_full = (fill[add_lvl] >= cap_eff);

  // pointers wrap at the capacity in use
  assign wr_inc = CNT_W'(wr_ptr[add_lvl]) + CNT_W'(1);
  assign rd_inc = CNT_W'(rd_ptr[take_lvl]) + CNT_W'(1);
  assign wr_adv = (wr_inc >= cap_eff) ? '0 : PTR_W'(wr_inc);
  assign rd_adv = (rd_inc >= cap_eff) ? '0 : PTR_W'(rd_inc);

  always_comb begin
    push_job      = '0;
    push_job.data = req.payload;
    if (!is_take) begin
      push_job.level = spmq_pkg::LEVEL_OUT_W'(add_lvl);
      push_job.addr  = spmq_pkg::MAX_ADDR_W'(32'(add_lvl) * 32'(FIFO_DEPTH)
                                             + 32'(wr_ptr[add_lvl]));
      if (add_full) begin
        push_job.op     = spmq_pkg::OP_NONE;
        push_job.status = spmq_pkg::ST_DROPPED;
      end else begin
        push_job.op     = spmq_pkg::OP_WRITE;
        push_job.status = spmq_pkg::ST_ADDED;
      end
    end else if (found) begin
      push_job.op     = spmq_pkg::OP_READ;
      push_job.status = spmq_pkg::ST_TAKEN;
      push_job.level  = spmq_pkg::LEVEL_OUT_W'(take_lvl);
      push_job.addr   = spmq_pkg::MAX_ADDR_W'(32'(take_lvl) * 32'(FIFO_DEPTH)
                                              + 32'(rd_ptr[take_lvl]));
    end else begin
      push_job.op     = spmq_pkg::OP_NONE;
      push_job.status = spmq_pkg::ST_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= spmq_pkg::CAP_RESET;
      for (int i = 0; i < LEVEL_COUNT; i++) begin
        rd_ptr[i] <= '0;
        wr_ptr[i] <= '0;
        fill[i]   <= '0;
      end
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (accept) begin
        if (!is_take && !add_full) begin
          wr_ptr[add_lvl] <= wr_adv;
          fill[add_lvl]   <= fill[add_lvl] + CNT_W'(1);
        end else if (is_take && found) begin
          rd_ptr[take_lvl] <= rd_adv;
          fill[take_lvl]   <= fill[take_lvl] - CNT_W'(1);
        end
      end
    end
  end

endmodule

/* hw/rtl/spmq_queue.sv */
module spmq_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  spmq_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop_ready,
  output spmq_pkg::job_t pop_job
);

  localparam int QW = (spmq_pkg::QUEUE_DEPTH > 1) ? $clog2(spmq_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(spmq_pkg::QUEUE_DEPTH + 1);

  spmq_pkg::job_t slots [spmq_pkg::QUEUE_DEPTH];
  logic [QW-1:0] wr_idx;
  logic [QW-1:0] rd_idx;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != CW'(spmq_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_job    = slots[rd_idx];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_idx] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_idx <= (wr_idx == QW'(spmq_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_idx + QW'(1);
      end
      if (do_pop) begin
        rd_idx <= (rd_idx == QW'(spmq_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_idx + QW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

/* hw/rtl/spmq_back.sv */
module spmq_back #(
  parameter int LEVEL_COUNT = spmq_pkg::LEVEL_COUNT_DEF,
  parameter int FIFO_DEPTH  = spmq_pkg::FIFO_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  spmq_pkg::job_t pop_job,
  spmq_out_if.source     rsp
);

  localparam int MEM_DEPTH = LEVEL_COUNT * FIFO_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  logic [spmq_pkg::PAYLOAD_W-1:0] mem [MEM_DEPTH];
  logic [spmq_pkg::PAYLOAD_W-1:0] rdata;
  logic [ADDR_W-1:0]              addr;
  logic                           out_valid;
  logic                           out_read;
  spmq_pkg::status_t              out_status;
  logic [spmq_pkg::LEVEL_OUT_W-1:0] out_level;
  logic                           do_pop;

  // the output register frees when its request is taken
  assign pop_ready = !out_valid || rsp.ready;
  assign do_pop    = pop_valid && pop_ready;
  assign addr      = ADDR_W'(pop_job.addr);

  always_ff @(posedge clk) begin
    if (do_pop) begin
      case (pop_job.op)
        spmq_pkg::OP_WRITE: mem[addr] <= pop_job.data;
        spmq_pkg::OP_READ:  rdata     <= mem[addr];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_pop) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      out_read   <= (pop_job.op == spmq_pkg::OP_READ);
      out_status <= pop_job.status;
      out_level  <= pop_job.level;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.level_out   = out_level;
  assign rsp.payload_out = out_read ? rdata : '0;

endmodule

/* hw/rtl/spmq_checker.sv */
module spmq_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  status,
  input logic [31:0] payload_out,
  input logic [2:0]  level_out
);

  // a result held back stays offered
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result withdrawn while stalled");

  // nothing comes out in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result shown straight after reset");

  // adds and drops never carry a handle
  a_add_no_payload: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == spmq_pkg::ST_ADDED || status == spmq_pkg::ST_DROPPED)
    |-> payload_out == '0)
    else $error("handle shown on an add result");

  // an empty take reports neither handle nor level
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == spmq_pkg::ST_EMPTY |-> payload_out == '0 && level_out == '0)
    else $error("empty take with non-zero fields");

  // no result appears on an idle output unless a request was accepted before it
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid && !$past(req_valid && req_ready) |=> !rsp_valid)
    else $error("result without a request");

endmodule

bind strict_priority_multi_queue spmq_checker u_spmq_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .status      (rsp.status),
  .payload_out (rsp.payload_out),
  .level_out   (rsp.level_out)
);

/* tb/tb_strict_priority_multi_queue.sv */
module tb_strict_priority_multi_queue;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEVELS = spmq_pkg::LEVEL_COUNT_DEF;
  localparam int DEPTH = spmq_pkg::FIFO_DEPTH_DEF;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int PRIO_W = spmq_pkg::PRIO_W;
  localparam int PAYLOAD_W = spmq_pkg::PAYLOAD_W;
  localparam int LEVEL_OUT_W = spmq_pkg::LEVEL_OUT_W;
  localparam int CAP_W = spmq_pkg::CAP_W;
  localparam int ITEM_TARGET = 1100;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    spmq_pkg::action_t      action;
    logic [PRIO_W-1:0]      prio;
    logic [PAYLOAD_W-1:0]   handle;
  } handle_req_t;

  typedef struct packed {
    spmq_pkg::status_t      status;
    logic [PAYLOAD_W-1:0]   handle;
    logic [LEVEL_OUT_W-1:0] level;
  } handle_rsp_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  spmq_in_if  req_if ();
  spmq_out_if rsp_if ();

  strict_priority_multi_queue i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_if),
    .rsp       (rsp_if)
  );

  always #10 clk = ~clk;

  // shadow of the per-level rings
  logic [PAYLOAD_W-1:0] slot_mem [LEVELS*DEPTH];
  logic [PTR_W-1:0]     head_ptr [LEVELS];
  logic [PTR_W-1:0]     tail_ptr [LEVELS];
  logic [CAP_W-1:0]     level_fill [LEVELS];
  logic [CAP_W-1:0]     capacity_reg;

  handle_req_t handle_requests [$];
  handle_rsp_t owed_results [$];
  handle_rsp_t want;

  int fail_count = 0;
  int pushed_total = 0;
  int send_wait;
  int recv_wait;
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;
  int cap_plan [10];

  function automatic logic [PTR_W-1:0] ring_next(logic [PTR_W-1:0] p, logic [CAP_W-1:0] cap);
    logic [CAP_W-1:0] n;
    n = CAP_W'(p) + CAP_W'(1);
    return (n >= cap) ? '0 : n[PTR_W-1:0];
  endfunction

  function automatic handle_rsp_t serve_request(handle_req_t r);
    handle_rsp_t res;
    logic [CAP_W-1:0] cap;
    int lvl;
    bit found;
    res.status = spmq_pkg::ST_EMPTY;
    res.handle = '0;
    res.level = '0;
    cap = capacity_reg;
    if (cap == '0) cap = CAP_W'(1);
    else if (int'(cap) > DEPTH) cap = CAP_W'(DEPTH);
    if (r.action == spmq_pkg::ACT_ADD) begin
      lvl = (int'(r.prio) >= LEVELS) ? 0 : int'(r.prio);
      res.level = lvl[LEVEL_OUT_W-1:0];
      if (level_fill[lvl] >= cap) begin
        res.status = spmq_pkg::ST_DROPPED;
      end else begin
        slot_mem[lvl*DEPTH + int'(tail_ptr[lvl])] = r.handle;
        tail_ptr[lvl] = ring_next(tail_ptr[lvl], cap);
        level_fill[lvl] = level_fill[lvl] + CAP_W'(1);
        res.status = spmq_pkg::ST_ADDED;
      end
    end else begin
      found = 1'b0;
      for (int i = 0; i < LEVELS && !found; i++) begin
        if (level_fill[i] != '0) begin
          found = 1'b1;
          res.status = spmq_pkg::ST_TAKEN;
          res.level = i[LEVEL_OUT_W-1:0];
          res.handle = slot_mem[i*DEPTH + int'(head_ptr[i])];
          head_ptr[i] = ring_next(head_ptr[i], cap);
          level_fill[i] = level_fill[i] - CAP_W'(1);
        end
      end
    end
    return res;
  endfunction

  function automatic int idle_len(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic logic [PAYLOAD_W-1:0] random_handle();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  task automatic push_req(spmq_pkg::action_t a, int prio, logic [PAYLOAD_W-1:0] h);
    handle_req_t r;
    r.action = a;
    r.prio = prio[PRIO_W-1:0];
    r.handle = h;
    handle_requests.push_back(r);
    pushed_total++;
  endtask

  task automatic drain();
    while (handle_requests.size() != 0 || owed_results.size() != 0) @(negedge clk);
  endtask

  // only called with nothing in flight
  task automatic write_capacity(int v);
    drain();
    repeat (3) @(negedge clk);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v[CAP_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    capacity_reg = v[CAP_W-1:0];
    @(negedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        owed_results.push_back(serve_request(handle_requests.pop_front()));
        send_wait = idle_len(send_calm);
      end
      if (send_wait > 0 || handle_requests.size() == 0) begin
        if (send_wait > 0) send_wait--;
        req_if.valid <= 1'b0;
      end else begin
        req_if.valid <= 1'b1;
        req_if.action <= handle_requests[0].action;
        req_if.priority_req <= handle_requests[0].prio;
        req_if.payload <= handle_requests[0].handle;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (owed_results.size() == 0) begin
          note_failure($sformatf("ERROR: unexpected result status %0d payload %h level %0d",
                                 rsp_if.status, rsp_if.payload_out, rsp_if.level_out));
        end else begin
          want = owed_results.pop_front();
          if (rsp_if.status !== want.status || rsp_if.payload_out !== want.handle ||
              rsp_if.level_out !== want.level)
            note_failure($sformatf(
              {"ERROR: expected status %0d payload %h level %0d, ",
               "got status %0d payload %h level %0d"},
              want.status, want.handle, want.level,
              rsp_if.status, rsp_if.payload_out, rsp_if.level_out));
        end
      end
      if (recv_wait > 0) begin
        recv_wait--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        recv_wait = idle_len(recv_calm);
      end
    end
  end

  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (handle_requests.size() == 0 && owed_results.size() == 0))
        stalled = 0;
      else
        stalled++;
    end
    $display("FAIL strict_priority_multi_queue");
    $finish;
  end

  initial begin : stimulus
    int left [LEVELS];
    int lvl;
    int n;
    int add_pct;
    int focus;
    int plan_idx;
    int burst;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_if.valid = 1'b0;
    req_if.action = 1'b0;
    req_if.priority_req = '0;
    req_if.payload = '0;
    rsp_if.ready = 1'b0;
    for (int l = 0; l < LEVELS; l++) begin
      head_ptr[l] = '0;
      tail_ptr[l] = '0;
      level_fill[l] = '0;
    end
    capacity_reg = spmq_pkg::CAP_RESET;
    cap_plan = '{1, 31, 17, 2, 16, 0, 5, 12, 3, 8};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // take on empty, field extremes, out-of-range levels folded onto level 0
    push_req(spmq_pkg::ACT_TAKE, 15, '1);
    push_req(spmq_pkg::ACT_ADD, 0, '0);
    push_req(spmq_pkg::ACT_ADD, 7, '1);
    push_req(spmq_pkg::ACT_ADD, 15, 32'hA5A5_A5A5);
    push_req(spmq_pkg::ACT_ADD, 8, 32'h5A5A_5A5A);
    push_req(spmq_pkg::ACT_ADD, 3, random_handle());
    push_req(spmq_pkg::ACT_ADD, 7, random_handle());
    repeat (7) push_req(spmq_pkg::ACT_TAKE, 0, '0);

    // zero capacity behaves as one: second add is dropped
    write_capacity(0);
    push_req(spmq_pkg::ACT_ADD, 2, random_handle());
    push_req(spmq_pkg::ACT_ADD, 2, random_handle());
    push_req(spmq_pkg::ACT_ADD, 10, random_handle());
    repeat (3) push_req(spmq_pkg::ACT_TAKE, 5, '1);

    // fill every level to the brim so that every slot has been written before
    // capacity moves under held entries, then drain in priority order
    write_capacity(16);
    for (int l = 0; l < LEVELS; l++) left[l] = DEPTH;
    repeat (LEVELS*DEPTH) begin
      do begin
        lvl = $urandom_range(0, LEVELS - 1);
      end while (left[lvl] == 0);
      left[lvl]--;
      if (lvl == 0 && $urandom_range(0, 1) == 1)
        push_req(spmq_pkg::ACT_ADD, $urandom_range(LEVELS, 15), random_handle());
      else
        push_req(spmq_pkg::ACT_ADD, lvl, random_handle());
    end
    repeat (4) push_req(spmq_pkg::ACT_ADD, $urandom_range(0, 15), random_handle());
    repeat (LEVELS*DEPTH + 1) push_req(spmq_pkg::ACT_TAKE, $urandom_range(0, 15), $urandom);

    plan_idx = 0;
    burst = 0;
    while (pushed_total < ITEM_TARGET) begin
      if (burst % 4 == 0) begin
        write_capacity((plan_idx < 10) ? cap_plan[plan_idx] : $urandom_range(0, 31));
        plan_idx++;
      end
      while (handle_requests.size() != 0) @(negedge clk);
      send_calm = ($urandom_range(0, 4) == 0);
      recv_calm = ($urandom_range(0, 4) == 0);
      n = $urandom_range(6, 40);
      case ($urandom_range(0, 3))
        0: add_pct = 20;
        1: add_pct = 50;
        2: add_pct = 70;
        default: add_pct = 90;
      endcase
      focus = $urandom_range(0, 15);
      repeat (n) begin
        if ($urandom_range(0, 99) < add_pct)
          push_req(spmq_pkg::ACT_ADD,
                   ($urandom_range(0, 2) != 0) ? focus : $urandom_range(0, 15),
                   random_handle());
        else
          push_req(spmq_pkg::ACT_TAKE, $urandom_range(0, 15), $urandom);
      end
      burst++;
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("PASS strict_priority_multi_queue");
    else
      $display("FAIL strict_priority_multi_queue");
    $finish;
  end

endmodule
